// ===== hw/rtl/pab_pkg.sv =====
`timescale 1ns / 1ps

package pab_pkg;

    localparam int CH_W      = 8;
    localparam int PROD_W    = 2 * CH_W;
    localparam int CFG_IDX_W = 3;
    localparam int LANES     = 3;

    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [PROD_W-1:0] prod_t;

    localparam ch_t CH_MAX = ch_t'(255);

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_RGB    = 2'd2,
        MODE_RGBA   = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = CFG_IDX_W'(3);

    // Configuration as seen by the operand select stage
    typedef struct packed {
        mode_t mode;
        ch_t   tint_red;
        ch_t   tint_green;
        ch_t   tint_blue;
    } cfg_t;

    // Raw request payload
    typedef struct packed {
        ch_t dst_red;
        ch_t dst_green;
        ch_t dst_blue;
        ch_t dst_alpha;
        ch_t src_red;
        ch_t src_green;
        ch_t src_blue;
        ch_t src_alpha;
    } req_t;

    // One colour lane: d*(255-a) + s*a
    typedef struct packed {
        ch_t d;
        ch_t s;
        ch_t a;
    } lane_t;

    // Stage 1 -> stage 2: operands after mode selection
    typedef struct packed {
        lane_t [LANES-1:0] lane;
        ch_t               dst_alpha;
        ch_t               src_alpha;
    } op_t;

    // Stage 2 -> stage 3: undivided sums and the inverse alpha product
    typedef struct packed {
        prod_t [LANES-1:0] sum;
        prod_t             inv_prod;
    } sum_t;

    // Stage 3 output pixel
    typedef struct packed {
        ch_t red;
        ch_t green;
        ch_t blue;
        ch_t alpha;
    } pix_t;

    // floor(x / 255) for x <= 255*255
    function automatic ch_t div255(input prod_t x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{(CH_W + 1){1'b0}}, x[PROD_W-1:CH_W]} + (PROD_W + 1)'(1);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage

// ===== hw/rtl/pab_if.sv =====
`timescale 1ns / 1ps

interface pab_in_if;
    import pab_pkg::*;

    logic valid;
    logic ready;
    ch_t  dst_red;
    ch_t  dst_green;
    ch_t  dst_blue;
    ch_t  dst_alpha;
    ch_t  src_red;
    ch_t  src_green;
    ch_t  src_blue;
    ch_t  src_alpha;

    modport source (
        output valid, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

interface pab_out_if;
    import pab_pkg::*;

    logic valid;
    logic ready;
    ch_t  out_red;
    ch_t  out_green;
    ch_t  out_blue;
    ch_t  out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

// ===== hw/rtl/pab_sel.sv =====
`timescale 1ns / 1ps

// Stage 1: map the mode onto uniform lane operands
module pab_sel (
    input  logic          clk,
    input  logic          rst_n,
    input  pab_pkg::cfg_t cfg,
    input  logic          up_valid,
    output logic          up_ready,
    input  pab_pkg::req_t up_data,
    output logic          down_valid,
    input  logic          down_ready,
    output pab_pkg::op_t  down_data
);
    import pab_pkg::*;

    logic valid_reg;
    op_t  data_reg;
    op_t  data_next;
    ch_t  src_ch [LANES];
    ch_t  dst_ch [LANES];
    ch_t  tint_ch [LANES];

    assign dst_ch[0]  = up_data.dst_red;
    assign dst_ch[1]  = up_data.dst_green;
    assign dst_ch[2]  = up_data.dst_blue;
    assign src_ch[0]  = up_data.src_red;
    assign src_ch[1]  = up_data.src_green;
    assign src_ch[2]  = up_data.src_blue;
    assign tint_ch[0] = cfg.tint_red;
    assign tint_ch[1] = cfg.tint_green;
    assign tint_ch[2] = cfg.tint_blue;

    // Unused channels pass through: colour with a = 0, alpha with sa = 0
    always_comb
    begin
        data_next.dst_alpha = up_data.dst_alpha;
        data_next.src_alpha = up_data.src_alpha;
        for (int i = 0; i < LANES; i++)
        begin
            data_next.lane[i].d = dst_ch[i];
            data_next.lane[i].s = src_ch[i];
            data_next.lane[i].a = up_data.src_alpha;
        end
        case (cfg.mode)
            MODE_TEXT:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    data_next.lane[i].s = tint_ch[i];
                end
            end
            MODE_SINGLE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    data_next.lane[i].a = '0;
                end
            end
            MODE_RGB:
            begin
                data_next.src_alpha = '0;
                for (int i = 0; i < LANES; i++)
                begin
                    data_next.lane[i].a = CH_MAX;
                end
            end
            default:
            begin
                data_next.src_alpha = up_data.src_alpha;
            end
        endcase
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hw/rtl/pab_mult.sv =====
`timescale 1ns / 1ps

// Stage 2: per-lane products and the inverse alpha product
module pab_mult (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  pab_pkg::op_t  up_data,
    output logic          down_valid,
    input  logic          down_ready,
    output pab_pkg::sum_t down_data
);
    import pab_pkg::*;

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;

    // Sum never exceeds 255*255, so it fits the product width
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            data_next.sum[i] = prod_t'(up_data.lane[i].d) * prod_t'(CH_MAX - up_data.lane[i].a)
                             + prod_t'(up_data.lane[i].s) * prod_t'(up_data.lane[i].a);
        end
        data_next.inv_prod = prod_t'(CH_MAX - up_data.dst_alpha)
                           * prod_t'(CH_MAX - up_data.src_alpha);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hw/rtl/pab_div.sv =====
`timescale 1ns / 1ps

// Stage 3: divide by 255 and hold the result for the receiver
module pab_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  pab_pkg::sum_t up_data,
    output logic          down_valid,
    input  logic          down_ready,
    output pab_pkg::pix_t down_data
);
    import pab_pkg::*;

    logic valid_reg;
    pix_t data_reg;
    pix_t data_next;

    always_comb
    begin
        data_next.red   = div255(up_data.sum[0]);
        data_next.green = div255(up_data.sum[1]);
        data_next.blue  = div255(up_data.sum[2]);
        data_next.alpha = CH_MAX - div255(up_data.inv_prod);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ===== hw/rtl/pixel_alpha_blend.sv =====
`timescale 1ns / 1ps

// pixel_alpha_blend: 8-bit source-over compositing of one pixel pair per request.
//
// Channels: in_px (pab_in_if.sink) carries a destination and a source pixel;
// out_px (pab_out_if.source) returns the blended pixel. Both use valid/ready,
// a request moves on a clock edge where both are high.
// Configuration: cfg_we/cfg_index/cfg_wdata write blend_mode (0) and the
// text tint red/green/blue (1..3); other indexes are ignored. Write only
// while the pipeline is empty.
// Path: a request accepted on in_px is registered in the select, multiply and
// divide-by-255 stages in turn and is presented on out_px from the last one.
// Throughput: one request per cycle, with every stage register loading each
// cycle when the receiver keeps ready high.
// Stall: when out_px.ready is low each stage holds until the stage after it
// frees up; in_px.ready drops once all three stages are full. Nothing is lost.
// Reset: stages empty, blend_mode = rgba source-over, tint = white.
module pixel_alpha_blend #(
    parameter int IDX_W = pab_pkg::CFG_IDX_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  pab_pkg::ch_t     cfg_wdata,
    pab_in_if.sink           in_px,
    pab_out_if.source        out_px
);
    import pab_pkg::*;

    mode_t mode_reg;
    ch_t   tint_red_reg;
    ch_t   tint_green_reg;
    ch_t   tint_blue_reg;
    cfg_t  cfg;
    req_t  req;
    logic  s1_valid;
    logic  s2_valid;
    logic  s2_ready;
    op_t   s1_data;
    sum_t  s2_data;
    pix_t  s3_data;
    logic  s3_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RGBA;
            tint_red_reg   <= CH_MAX;
            tint_green_reg <= CH_MAX;
            tint_blue_reg  <= CH_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                IDX_W'(REG_BLEND_MODE): mode_reg       <= mode_t'(cfg_wdata[1:0]);
                IDX_W'(REG_TINT_RED):   tint_red_reg   <= cfg_wdata;
                IDX_W'(REG_TINT_GREEN): tint_green_reg <= cfg_wdata;
                IDX_W'(REG_TINT_BLUE):  tint_blue_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.tint_red   = tint_red_reg;
    assign cfg.tint_green = tint_green_reg;
    assign cfg.tint_blue  = tint_blue_reg;

    assign req.dst_red   = in_px.dst_red;
    assign req.dst_green = in_px.dst_green;
    assign req.dst_blue  = in_px.dst_blue;
    assign req.dst_alpha = in_px.dst_alpha;
    assign req.src_red   = in_px.src_red;
    assign req.src_green = in_px.src_green;
    assign req.src_blue  = in_px.src_blue;
    assign req.src_alpha = in_px.src_alpha;

    pab_sel u_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (in_px.valid),
        .up_ready   (in_px.ready),
        .up_data    (req),
        .down_valid (s1_valid),
        .down_ready (s2_ready),
        .down_data  (s1_data)
    );

    pab_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s2_ready),
        .up_data    (s1_data),
        .down_valid (s2_valid),
        .down_ready (s3_ready),
        .down_data  (s2_data)
    );

    pab_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s2_valid),
        .up_ready   (s3_ready),
        .up_data    (s2_data),
        .down_valid (out_px.valid),
        .down_ready (out_px.ready),
        .down_data  (s3_data)
    );

    assign out_px.out_red   = s3_data.red;
    assign out_px.out_green = s3_data.green;
    assign out_px.out_blue  = s3_data.blue;
    assign out_px.out_alpha = s3_data.alpha;

    // A moving stage 1 always fills stage 2
    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s2_ready |=> s2_valid)
        else $error("stage 2 lost a request from stage 1");

    // A moving stage 2 always fills the output stage
    a_s2_to_s3: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && s3_ready |=> out_px.valid)
        else $error("output stage lost a request from stage 2");

    // Full pipeline with a stalled receiver must push back on the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s2_valid && out_px.valid && !out_px.ready |-> !in_px.ready)
        else $error("input accepted while pipeline is full and stalled");

endmodule

// ===== verif/tb_pixel_alpha_blend.sv =====
`timescale 1ns / 1ps

module tb_pixel_alpha_blend;
    import pab_pkg::*;

    localparam int PIPE_LAT     = 3;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int DIR_PATTERNS = 5;

    // Expected-pixel store plus a shadow of the blend registers
    class blend_scoreboard;
        mode_t mode;
        ch_t   tint_r;
        ch_t   tint_g;
        ch_t   tint_b;
        pix_t  expected_pixels[$];
        int    errors;

        function new();
            mode   = MODE_RGBA;
            tint_r = CH_MAX;
            tint_g = CH_MAX;
            tint_b = CH_MAX;
            errors = 0;
        endfunction

        // Register shadow; only the low bits of the mode survive, indexes above 3 do nothing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, ch_t data);
            case (idx)
                REG_BLEND_MODE: mode   = mode_t'(data[1:0]);
                REG_TINT_RED:   tint_r = data;
                REG_TINT_GREEN: tint_g = data;
                REG_TINT_BLUE:  tint_b = data;
                default: ;
            endcase
        endfunction

        // (d*(255-a) + s*a) / 255, truncating
        function ch_t mix_color(ch_t d, ch_t s, ch_t a);
            int unsigned full;
            full = CH_MAX;
            return ch_t'((int'(d) * (full - a) + int'(s) * a) / full);
        endfunction

        // 255 - (255-d)*(255-s)/255, truncating
        function ch_t mix_alpha(ch_t d, ch_t s);
            int unsigned full;
            full = CH_MAX;
            return ch_t'(full - ((full - d) * (full - s)) / full);
        endfunction

        function pix_t blend_pixel(req_t px);
            pix_t res;
            res.red   = px.dst_red;
            res.green = px.dst_green;
            res.blue  = px.dst_blue;
            res.alpha = px.dst_alpha;
            case (mode)
                MODE_TEXT:
                begin
                    res.red   = mix_color(px.dst_red,   tint_r, px.src_alpha);
                    res.green = mix_color(px.dst_green, tint_g, px.src_alpha);
                    res.blue  = mix_color(px.dst_blue,  tint_b, px.src_alpha);
                    res.alpha = mix_alpha(px.dst_alpha, px.src_alpha);
                end
                MODE_SINGLE:
                begin
                    res.alpha = mix_alpha(px.dst_alpha, px.src_alpha);
                end
                MODE_RGB:
                begin
                    res.red   = mix_color(px.dst_red,   px.src_red,   CH_MAX);
                    res.green = mix_color(px.dst_green, px.src_green, CH_MAX);
                    res.blue  = mix_color(px.dst_blue,  px.src_blue,  CH_MAX);
                end
                default:
                begin
                    res.red   = mix_color(px.dst_red,   px.src_red,   px.src_alpha);
                    res.green = mix_color(px.dst_green, px.src_green, px.src_alpha);
                    res.blue  = mix_color(px.dst_blue,  px.src_blue,  px.src_alpha);
                    res.alpha = mix_alpha(px.dst_alpha, px.src_alpha);
                end
            endcase
            return res;
        endfunction

        function void note_request(req_t px);
            expected_pixels.push_back(blend_pixel(px));
        endfunction

        function void check_field(string name, ch_t want, ch_t got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_pixel(pix_t got);
            pix_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d, expected none",
                         $time, got.red, got.green, got.blue, got.alpha);
                return;
            end
            want = expected_pixels.pop_front();
            check_field("out_red",   want.red,   got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue",  want.blue,  got.blue);
            check_field("out_alpha", want.alpha, got.alpha);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    ch_t                  cfg_wdata;
    int                   cycle_count = 0;
    bit                   send_burst = 1'b0;
    bit                   recv_burst = 1'b0;
    blend_scoreboard      board = new();

    pab_in_if  in_px ();
    pab_out_if out_px ();

    pixel_alpha_blend i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_px     (in_px.sink),
        .out_px    (out_px.source)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Random wait, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    // Channel value biased toward the ends of the range
    function automatic ch_t rand_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_MAX;
            2:       return CH_MAX - ch_t'(1);
            default: return ch_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic req_t rand_pixel();
        req_t px;
        px.dst_red   = rand_channel();
        px.dst_green = rand_channel();
        px.dst_blue  = rand_channel();
        px.dst_alpha = rand_channel();
        px.src_red   = rand_channel();
        px.src_green = rand_channel();
        px.src_blue  = rand_channel();
        px.src_alpha = rand_channel();
        return px;
    endfunction

    // Hand one request to the block; valid stays high for a following request
    task automatic send_pixel(input req_t px);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            in_px.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_px.valid     <= 1'b1;
        in_px.dst_red   <= px.dst_red;
        in_px.dst_green <= px.dst_green;
        in_px.dst_blue  <= px.dst_blue;
        in_px.dst_alpha <= px.dst_alpha;
        in_px.src_red   <= px.src_red;
        in_px.src_green <= px.src_green;
        in_px.src_blue  <= px.src_blue;
        in_px.src_alpha <= px.src_alpha;
        do
            @(posedge clk);
        while (!in_px.ready);
        board.note_request(px);
    endtask

    // Stop sending and let the pipeline empty out
    task automatic drain_pipe();
        in_px.valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // Write all four registers, then one index the block should ignore
    task automatic program_regs(input ch_t mode_val, input ch_t r, input ch_t g,
                                input ch_t b, input logic [CFG_IDX_W-1:0] junk_idx,
                                input ch_t junk_val);
        logic [CFG_IDX_W-1:0] idx [5];
        ch_t                  val [5];
        idx = '{REG_BLEND_MODE, REG_TINT_RED, REG_TINT_GREEN, REG_TINT_BLUE, junk_idx};
        val = '{mode_val, r, g, b, junk_val};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            board.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, each accepted pixel goes to the checker
    initial
    begin
        pix_t got;
        int   stall;
        out_px.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(recv_burst);
            if (stall > 0)
            begin
                out_px.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_px.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_px.valid);
            got.red   = out_px.out_red;
            got.green = out_px.out_green;
            got.blue  = out_px.out_blue;
            got.alpha = out_px.out_alpha;
            board.check_pixel(got);
        end
    end

    // Request side: reset, directed patterns per mode, then random phases
    initial
    begin
        mode_t dir_modes [4];
        req_t  px;
        ch_t   mode_val;
        ch_t   tr;
        ch_t   tg;
        ch_t   tb;

        dir_modes = '{MODE_RGBA, MODE_TEXT, MODE_SINGLE, MODE_RGB};
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        in_px.valid     <= 1'b0;
        in_px.dst_red   <= '0;
        in_px.dst_green <= '0;
        in_px.dst_blue  <= '0;
        in_px.dst_alpha <= '0;
        in_px.src_red   <= '0;
        in_px.src_green <= '0;
        in_px.src_blue  <= '0;
        in_px.src_alpha <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first mode runs on reset values, the rest set tints of 0, 0x80 and 255
        // and a mode value with its upper bits set
        for (int k = 0; k < 4; k++)
        begin
            if (k > 0)
            begin
                drain_pipe();
                program_regs({6'h3f, dir_modes[k]}, '0, 8'h80, CH_MAX,
                             CFG_IDX_W'(4 + k), 8'h5a);
            end
            for (int j = 0; j < DIR_PATTERNS; j++)
            begin
                case (j)
                    0: px = '0;
                    1: px = '1;
                    2: px = '{dst_red: CH_MAX, dst_green: CH_MAX, dst_blue: CH_MAX,
                              dst_alpha: 8'h00, src_red: 8'h00, src_green: 8'h00,
                              src_blue: 8'h00, src_alpha: 8'h80};
                    3: px = '{dst_red: 8'h00, dst_green: 8'h00, dst_blue: 8'h00,
                              dst_alpha: CH_MAX, src_red: CH_MAX, src_green: CH_MAX,
                              src_blue: CH_MAX, src_alpha: 8'h01};
                    default: px = '{dst_red: 8'haa, dst_green: 8'haa, dst_blue: 8'haa,
                                    dst_alpha: 8'haa, src_red: 8'h55, src_green: 8'h55,
                                    src_blue: 8'h55, src_alpha: 8'h55};
                endcase
                send_pixel(px);
            end
        end

        // Random phases, every mode at least twice, tints at both ends early on
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_pipe();
            mode_val = {6'($urandom_range(0, 63)), p[1:0]};
            case (p)
                0:
                begin
                    tr = '0;
                    tg = '0;
                    tb = '0;
                end
                1:
                begin
                    tr = CH_MAX;
                    tg = CH_MAX;
                    tb = CH_MAX;
                end
                default:
                begin
                    tr = ch_t'($urandom_range(0, 255));
                    tg = ch_t'($urandom_range(0, 255));
                    tb = ch_t'($urandom_range(0, 255));
                end
            endcase
            program_regs(mode_val, tr, tg, tb, CFG_IDX_W'($urandom_range(4, 7)),
                         ch_t'($urandom_range(0, 255)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(rand_pixel());
        end

        // Let everything come out, then report
        in_px.valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pab_pkg.sv
hw/rtl/pab_if.sv
hw/rtl/pab_sel.sv
hw/rtl/pab_mult.sv
hw/rtl/pab_div.sv
hw/rtl/pixel_alpha_blend.sv
verif/tb_pixel_alpha_blend.sv
